[hw/rtl/tvts_pkg.sv]
// Shared types, constants and the pitch table of the two-voice tracker synthesizer.
package tvts_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ENV,
        S_AMP,
        S_MIX,
        S_FILT,
        S_OUT
    } t_state;

    // Envelope stage of one voice.
    typedef enum logic [1:0] {
        ST_RELEASE = 2'd0,
        ST_ATTACK  = 2'd1,
        ST_HOLD    = 2'd2
    } t_stage;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;       // clear one song table row
        logic wr;        // store a song table entry
        logic tick;      // row handling, counters and song table read
        logic env;       // phase and envelope update
        logic amp;       // sawtooth amplitude
        logic mix;       // voice scaling and sum
        logic filt;      // low-pass filter update
        logic out_load;  // output scaling and output register load
    } t_dp_cmd;

    // Commands to one voice.
    typedef struct packed {
        logic start;     // row start: act on the latched note
        logic gate;      // gate tick: release a pending note
        logic env;       // advance phase and envelope
        logic latch;     // latch the note code read from the song table
    } t_voice_cmd;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SAMPLES_PER_ROW = 3'd0;
    localparam logic [2:0] CFG_GATE_OFF_SAMPLE = 3'd1;
    localparam logic [2:0] CFG_SONG_ROWS       = 3'd2;
    localparam logic [2:0] CFG_ATTACK_STEP     = 3'd3;
    localparam logic [2:0] CFG_HOLD_DECAY      = 3'd4;
    localparam logic [2:0] CFG_RELEASE_DECAY   = 3'd5;
    localparam logic [2:0] CFG_FILTER_GAIN     = 3'd6;

    // Configuration reset values.
    localparam logic [15:0] RST_SAMPLES_PER_ROW = 16'd4000;
    localparam logic [15:0] RST_GATE_OFF_SAMPLE = 16'd3000;
    localparam logic [7:0]  RST_SONG_ROWS       = 8'd128;
    localparam logic [15:0] RST_ATTACK_STEP     = 16'd328;
    localparam logic [15:0] RST_HOLD_DECAY      = 16'd65529;
    localparam logic [15:0] RST_RELEASE_DECAY   = 16'd65405;
    localparam logic [15:0] RST_FILTER_GAIN     = 16'd19661;

    // Note codes.
    localparam logic [5:0] CODE_CONT = 6'd0;
    localparam logic [5:0] CODE_END  = 6'd48;

    // Level constants in Q2.16.
    localparam logic [17:0] LEVEL_MAX  = 18'h3FFFF;
    localparam logic [17:0] LEVEL_HALF = 18'd32768;
    localparam logic [17:0] LEVEL_ONE  = 18'd65536;

    // Waveform and output scaling constants.
    localparam logic signed [18:0] SAW_OFFSET = 19'sd85197;
    localparam logic signed [18:0] SAW_SLOPE  = 19'sd170394;
    localparam logic signed [18:0] OUT_GAIN   = 19'sd5000;

    // Phase increments of the 47 semitones as 32-bit phase fractions.
    localparam logic [31:0] PITCH_ROM [47] = '{
        32'd6748811,  32'd7150116,  32'd7575285,  32'd8025735,  32'd8502970,
        32'd9008582,  32'd9544261,  32'd10111792, 32'd10713070, 32'd11350103,
        32'd12025015, 32'd12740059, 32'd13497623, 32'd14300233, 32'd15150569,
        32'd16051469, 32'd17005939, 32'd18017165, 32'd19088521, 32'd20223584,
        32'd21426141, 32'd22700205, 32'd24050030, 32'd25480119, 32'd26995246,
        32'd28600466, 32'd30301139, 32'd32102938, 32'd34011878, 32'd36034330,
        32'd38177043, 32'd40447168, 32'd42852281, 32'd45400411, 32'd48100060,
        32'd50960238, 32'd53990491, 32'd57200931, 32'd60602278, 32'd64205876,
        32'd68023757, 32'd72068660, 32'd76354085, 32'd80894335, 32'd85704563,
        32'd90800821, 32'd96200119
    };

    // Pitch word of a note code; codes that are not notes give zero.
    function automatic logic [31:0] pitch_word(input logic [5:0] code);
        if (code != CODE_CONT && code < CODE_END) begin
            return PITCH_ROM[code - 6'd1];
        end
        return 32'd0;
    endfunction

endpackage

[hw/rtl/tvts_voice.sv]
// One voice: note latch, phase accumulator and envelope with its own multiplier.
module tvts_voice import tvts_pkg::*; #(
    parameter int PHASE_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_voice_cmd  i_cmd,
    input  logic [5:0]  i_note,
    input  logic [15:0] i_attack_step,
    input  logic [15:0] i_hold_decay,
    input  logic [15:0] i_release_decay,
    output logic [17:0] o_level,
    output logic [15:0] o_p16
);

    localparam int ROM_SHIFT = 32 - PHASE_BITS;

    logic [PHASE_BITS-1:0] r_phase, n_phase;
    logic [PHASE_BITS-1:0] r_inc, n_inc;
    logic [17:0]           r_level, n_level;
    t_stage                r_stage, n_stage;
    logic [5:0]            r_latched, n_latched;

    logic [31:0] rom_word;
    logic [32:0] rom_round;
    logic [17:0] half_dist;
    logic [17:0] mul_a;
    logic [15:0] mul_b;
    logic [33:0] prod;
    logic [17:0] scaled;
    logic [18:0] att_sum;
    logic [17:0] att_level;

    // Round the 32-bit pitch word to the phase width.
    assign rom_word  = pitch_word(r_latched);
    assign rom_round = ({rom_word, 1'b0} >> ROM_SHIFT) + 33'd1;

    // Hold pulls the distance from one half; release scales the level itself.
    assign half_dist = (r_level >= LEVEL_HALF) ? (r_level - LEVEL_HALF)
                                               : (LEVEL_HALF - r_level);
    assign mul_a     = (r_stage == ST_HOLD) ? half_dist : r_level;
    assign mul_b     = (r_stage == ST_HOLD) ? i_hold_decay : i_release_decay;
    assign prod      = mul_a * mul_b;
    assign scaled    = prod[33:16];

    // Attack step with saturation at the top of the level range.
    assign att_sum   = {1'b0, r_level} + {3'b000, i_attack_step};
    assign att_level = (att_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : att_sum[17:0];

    // Next state of the voice.
    always_comb begin
        n_phase   = r_phase;
        n_inc     = r_inc;
        n_level   = r_level;
        n_stage   = r_stage;
        n_latched = r_latched;

        if (i_cmd.start) begin
            if (r_latched == CODE_END) begin
                n_stage = ST_RELEASE;
            end else if (r_latched != CODE_CONT && r_latched < CODE_END) begin
                n_inc   = rom_round[PHASE_BITS:1];
                n_stage = ST_ATTACK;
            end
        end else if (i_cmd.gate) begin
            if (r_latched != CODE_CONT) begin
                n_stage = ST_RELEASE;
            end
        end

        if (i_cmd.latch) begin
            n_latched = i_note;
        end

        if (i_cmd.env) begin
            n_phase = r_phase + r_inc;
            case (r_stage)
                ST_ATTACK: begin
                    n_level = att_level;
                    if (att_level >= LEVEL_ONE) begin
                        n_stage = ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    n_level = (r_level >= LEVEL_HALF) ? (LEVEL_HALF + scaled)
                                                      : (LEVEL_HALF - scaled);
                end
                default: begin
                    n_level = scaled;
                end
            endcase
        end
    end

    // Voice state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_inc     <= '0;
            r_level   <= '0;
            r_stage   <= ST_RELEASE;
            r_latched <= CODE_CONT;
        end else begin
            r_phase   <= n_phase;
            r_inc     <= n_inc;
            r_level   <= n_level;
            r_stage   <= n_stage;
            r_latched <= n_latched;
        end
    end

    assign o_level = r_level;
    assign o_p16   = r_phase[PHASE_BITS-1 -: 16];

endmodule

[hw/rtl/tvts_dp.sv]
// Datapath: configuration, counters, song table, voices, mixer, filter and output.
module tvts_dp import tvts_pkg::*; #(
    parameter int ROWS       = 128,
    parameter int PHASE_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_voice_sel,
    input  logic [6:0]         i_row_index,
    input  logic [5:0]         i_note_code,
    output logic               o_clr_last,
    output logic signed [15:0] o_sample,
    output logic [6:0]         o_current_row
);

    localparam int          AW     = $clog2(ROWS);
    localparam int          RW     = (AW > 7) ? AW : 7;
    localparam logic [10:0] ROWS_W = 11'(ROWS);

    // Configuration registers.
    logic [15:0] r_samples_per_row, r_gate_off, r_attack_step;
    logic [15:0] r_hold_decay, r_release_decay, r_filter_gain;
    logic [7:0]  r_song_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples_per_row <= RST_SAMPLES_PER_ROW;
            r_gate_off        <= RST_GATE_OFF_SAMPLE;
            r_song_rows       <= RST_SONG_ROWS;
            r_attack_step     <= RST_ATTACK_STEP;
            r_hold_decay      <= RST_HOLD_DECAY;
            r_release_decay   <= RST_RELEASE_DECAY;
            r_filter_gain     <= RST_FILTER_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAMPLES_PER_ROW: r_samples_per_row <= i_cfg_data;
                CFG_GATE_OFF_SAMPLE: r_gate_off        <= i_cfg_data;
                CFG_SONG_ROWS:       r_song_rows       <= i_cfg_data[7:0];
                CFG_ATTACK_STEP:     r_attack_step     <= i_cfg_data;
                CFG_HOLD_DECAY:      r_hold_decay      <= i_cfg_data;
                CFG_RELEASE_DECAY:   r_release_decay   <= i_cfg_data;
                CFG_FILTER_GAIN:     r_filter_gain     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Tick and row counters.
    logic [15:0] r_tick, n_tick, tick_inc;
    logic [6:0]  r_row, n_row, row_inc;
    logic        r_start;
    logic        row_start, gate_hit;

    assign tick_inc  = r_tick + 16'd1;
    assign row_inc   = r_row + 7'd1;
    assign row_start = i_cmd.tick && (r_tick == 16'd0);
    assign gate_hit  = i_cmd.tick && (r_tick != 16'd0) && (r_tick == r_gate_off);

    always_comb begin
        n_tick = r_tick;
        n_row  = r_row;
        if (i_cmd.tick) begin
            if (tick_inc == r_samples_per_row) begin
                n_tick = '0;
                if (({1'b0, row_inc} == r_song_rows) || (11'(row_inc) >= ROWS_W)) begin
                    n_row = '0;
                end else begin
                    n_row = row_inc;
                end
            end else begin
                n_tick = tick_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_row   <= '0;
            r_start <= 1'b0;
        end else begin
            r_tick <= n_tick;
            r_row  <= n_row;
            if (i_cmd.tick) begin
                r_start <= row_start;
            end
        end
    end

    // Song table: one memory per voice, cleared row by row after reset.
    logic [5:0]    mem0 [ROWS];
    logic [5:0]    mem1 [ROWS];
    logic [5:0]    r_rd0, r_rd1;
    logic [AW-1:0] r_clr_addr;
    logic [RW-1:0] wr_wide, rd_wide;
    logic [AW-1:0] wr_addr, rd_addr, mem_addr;
    logic [5:0]    wr_code, mem_data;
    logic          wr_ok, we0, we1;

    assign wr_wide    = RW'(i_row_index);
    assign rd_wide    = RW'(r_row);
    assign wr_addr    = wr_wide[AW-1:0];
    assign rd_addr    = rd_wide[AW-1:0];
    assign wr_ok      = i_cmd.wr && (11'(i_row_index) < ROWS_W);
    assign wr_code    = (i_note_code > CODE_END) ? CODE_CONT : i_note_code;
    assign mem_addr   = i_cmd.clr ? r_clr_addr : wr_addr;
    assign mem_data   = i_cmd.clr ? CODE_CONT : wr_code;
    assign we0        = i_cmd.clr || (wr_ok && !i_voice_sel);
    assign we1        = i_cmd.clr || (wr_ok && i_voice_sel);
    assign o_clr_last = (r_clr_addr == AW'(ROWS - 1));

    always_ff @(posedge i_clk) begin
        if (we0) begin
            mem0[mem_addr] <= mem_data;
        end
        if (i_cmd.tick) begin
            r_rd0 <= mem0[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            mem1[mem_addr] <= mem_data;
        end
        if (i_cmd.tick) begin
            r_rd1 <= mem1[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // The two voices.
    t_voice_cmd  vcmd;
    logic [17:0] level0, level1;
    logic [15:0] p16_0, p16_1;

    assign vcmd.start = row_start;
    assign vcmd.gate  = gate_hit;
    assign vcmd.env   = i_cmd.env;
    assign vcmd.latch = i_cmd.env && r_start;

    tvts_voice #(.PHASE_BITS(PHASE_BITS)) u_voice0 (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (vcmd),
        .i_note          (r_rd0),
        .i_attack_step   (r_attack_step),
        .i_hold_decay    (r_hold_decay),
        .i_release_decay (r_release_decay),
        .o_level         (level0),
        .o_p16           (p16_0)
    );

    tvts_voice #(.PHASE_BITS(PHASE_BITS)) u_voice1 (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (vcmd),
        .i_note          (r_rd1),
        .i_attack_step   (r_attack_step),
        .i_hold_decay    (r_hold_decay),
        .i_release_decay (r_release_decay),
        .o_level         (level1),
        .o_p16           (p16_1)
    );

    // Shared signed multiplier for the sawtooth, mix, filter and output steps.
    logic signed [17:0] r_amp;
    logic signed [21:0] r_sum;
    logic signed [23:0] r_filt;
    logic signed [24:0] diff;
    logic signed [24:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [43:0] mul_p;

    assign diff = $signed({{3{r_sum[21]}}, r_sum}) - $signed({r_filt[23], r_filt});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.amp) begin
            mul_a = $signed({9'd0, p16_0});
            mul_b = SAW_SLOPE;
        end else if (i_cmd.mix) begin
            mul_a = $signed({{7{r_amp[17]}}, r_amp});
            mul_b = $signed({1'b0, level0});
        end else if (i_cmd.filt) begin
            mul_a = diff;
            mul_b = $signed({3'd0, r_filter_gain});
        end else if (i_cmd.out_load) begin
            mul_a = $signed({r_filt[23], r_filt});
            mul_b = OUT_GAIN;
        end
    end

    assign mul_p = mul_a * mul_b;

    // Post-multiply arithmetic of each step.
    logic signed [18:0] amp_full;
    logic signed [21:0] voice0, voice1, sum_new;
    logic signed [23:0] filt_new;
    logic signed [43:0] q_adj;
    logic signed [27:0] q_shift;
    logic signed [15:0] sat;

    assign amp_full = SAW_OFFSET - $signed({1'b0, mul_p[33:16]});
    assign voice0   = mul_p[37:16];
    assign voice1   = p16_1[15] ? $signed({4'd0, level1}) : -$signed({4'd0, level1});
    assign sum_new  = voice0 + voice1;
    assign filt_new = r_filt + mul_p[39:16];
    assign q_adj    = mul_p + (mul_p[43] ? 44'sd65535 : 44'sd0);
    assign q_shift  = q_adj[43:16];

    always_comb begin
        if (q_shift > 28'sd32767) begin
            sat = 16'sh7FFF;
        end else if (q_shift < -28'sd32768) begin
            sat = 16'sh8000;
        end else begin
            sat = q_shift[15:0];
        end
    end

    // Filter memory is part of the state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= '0;
        end else if (i_cmd.filt) begin
            r_filt <= filt_new;
        end
    end

    // Intermediate and output words.
    logic signed [15:0] r_sample;
    logic [6:0]         r_out_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.amp) begin
            r_amp <= amp_full[17:0];
        end
        if (i_cmd.mix) begin
            r_sum <= sum_new;
        end
        if (i_cmd.out_load) begin
            r_sample  <= sat;
            r_out_row <= r_row;
        end
    end

    assign o_sample      = r_sample;
    assign o_current_row = r_out_row;

endmodule

[hw/rtl/tvts_ctrl.sv]
// Controller: table clearing, input handshake, step sequence and output valid.
module tvts_ctrl import tvts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_func,
    input  logic    i_ready,
    input  logic    i_clr_last,
    output logic    o_ready,
    output logic    o_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // State register and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_func) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.tick = 1'b1;
                        n_state    = S_ENV;
                    end
                end
            end
            S_ENV: begin
                o_cmd.env = 1'b1;
                n_state   = S_AMP;
            end
            S_AMP: begin
                o_cmd.amp = 1'b1;
                n_state   = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = S_FILT;
            end
            S_FILT: begin
                o_cmd.filt = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                // Wait until the output register is free.
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A loaded word stays valid until it is taken.
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

[hw/rtl/two_voice_tracker_synth_unit.sv]
// Top level of the two-voice tracker synthesizer.
//
//  Channel  | Handshake                    | Word
//  ---------+------------------------------+------------------------------------------
//  input    | i_valid / o_ready            | i_func, i_voice_sel, i_row_index, i_note_code
//  output   | o_valid / i_ready            | o_sample, o_current_row
//  config   | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// A song table write is done in the accepting cycle; the next word can be accepted in the cycle after.
// A tick runs through the accepting cycle, then envelope, sawtooth, mix, filter and output steps;
// the sawtooth, mix, filter and output steps share one signed multiplier in the datapath.
// After reset the song table is cleared one row per cycle, all ROWS rows, with o_ready low.
// A stalled output word holds the block in its output step; input is still taken while
// a finished word waits.
module two_voice_tracker_synth_unit import tvts_pkg::*; #(
    parameter int ROWS       = 128,
    parameter int PHASE_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic               i_voice_sel,
    input  logic [6:0]         i_row_index,
    input  logic [5:0]         i_note_code,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_sample,
    output logic [6:0]         o_current_row,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);

    t_dp_cmd cmd;
    logic    clr_last;

    // Sequencing.
    tvts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_func     (i_func),
        .i_ready    (i_ready),
        .i_clr_last (clr_last),
        .o_ready    (o_ready),
        .o_valid    (o_valid),
        .o_cmd      (cmd)
    );

    // Arithmetic and storage.
    tvts_dp #(
        .ROWS       (ROWS),
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_voice_sel   (i_voice_sel),
        .i_row_index   (i_row_index),
        .i_note_code   (i_note_code),
        .o_clr_last    (clr_last),
        .o_sample      (o_sample),
        .o_current_row (o_current_row)
    );

endmodule

[hw/rtl/tvts_checker.sv]
// Port-level checks of the tracker synthesizer and their binding to the top level.
module tvts_checker #(
    parameter int ROWS = 128
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_in_ready,
    input logic        i_func,
    input logic        i_out_valid,
    input logic        i_ready,
    input logic [15:0] i_sample,
    input logic [6:0]  i_current_row
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_ready |=> i_out_valid && $stable(i_sample) && $stable(i_current_row))
        else $error("output word changed while stalled");

    // The reported row always lies inside the song table.
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_current_row) < ROWS))
        else $error("current row outside the song table");

    // A tick keeps the block busy in the following cycle.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_in_ready && !i_func |=> !i_in_ready)
        else $error("input taken during a tick");

    // A table write does not stall the input.
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_in_ready && i_func |=> i_in_ready)
        else $error("table write stalled the input");

    // A new output word appears as the block returns to accepting input.
    a_word_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("output word without return to idle");

endmodule

bind two_voice_tracker_synth_unit tvts_checker #(.ROWS(ROWS)) u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .i_in_ready    (o_ready),
    .i_func        (i_func),
    .i_out_valid   (o_valid),
    .i_ready       (i_ready),
    .i_sample      (o_sample),
    .i_current_row (o_current_row)
);
